### hw/rtl/hftsf_pkg.sv
// ----------------------------------------------------------------------------
// Horizontal four-tap subpixel filter package
// Shared widths, register indexes and the cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package hftsf_pkg;

   localparam int PixelWidth  = 8;
   localparam int TapWidth    = 16;
   localparam int HalfWidth   = TapWidth - 1;
   localparam int ProdWidth   = PixelWidth + 1 + HalfWidth;
   localparam int SumWidth    = ProdWidth + 3;
   localparam int NumTaps     = 4;
   localparam int FillWidth   = 2;
   localparam int CsrIdxWidth = 3;
   localparam int RoundBias   = 32;
   localparam int RoundShift  = 6;

   localparam logic [FillWidth-1:0] FillFull = FillWidth'(NumTaps - 1);
   localparam logic signed [SumWidth-1:0] SatLimit =
      SumWidth'(256 << RoundShift);

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TAP_LEFT      = 3'd0,
      CSR_TAP_CENTER    = 3'd1,
      CSR_TAP_RIGHT     = 3'd2,
      CSR_TAP_FAR_RIGHT = 3'd3
   } csr_index_type;

   localparam logic [TapWidth-1:0] TapLeftReset     = 16'sd0;
   localparam logic [TapWidth-1:0] TapCenterReset   = 16'sd128;
   localparam logic [TapWidth-1:0] TapRightReset    = 16'sd0;
   localparam logic [TapWidth-1:0] TapFarRightReset = 16'sd0;

   typedef struct packed {
      logic shift;
      logic advance;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### hw/rtl/hftsf_cell.sv
// ----------------------------------------------------------------------------
// Filter cell
// Holds one window pixel, hands it to the older neighbor on each request,
// and forms the registered product of that pixel with its halved tap.
// ----------------------------------------------------------------------------
`default_nettype none

module hftsf_cell (
   input  wire logic                                    clock,
   input  wire hftsf_pkg::cell_ctrl_type                ctrl,
   input  wire logic [hftsf_pkg::PixelWidth-1:0]        pix_in,
   input  wire logic signed [hftsf_pkg::TapWidth-1:0]   tap,
   output logic [hftsf_pkg::PixelWidth-1:0]             pix_out,
   output logic signed [hftsf_pkg::ProdWidth-1:0]       prod_out
);
   import hftsf_pkg::*;

   logic [PixelWidth-1:0]        pix_ff;
   logic [PixelWidth-1:0]        pix_in_w;
   logic signed [ProdWidth-1:0]  prod_ff;
   logic signed [ProdWidth-1:0]  prod_in;
   logic signed [HalfWidth-1:0]  tap_half;

   always_comb begin
      tap_half = HalfWidth'(tap >>> 1);
      prod_in  = $signed({1'b0, pix_ff}) * tap_half;
      pix_in_w = ctrl.shift ? pix_in : pix_ff;
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in_w;
      if (ctrl.advance) begin
         prod_ff <= prod_in;
      end
   end

   assign pix_out  = pix_ff;
   assign prod_out = prod_ff;

endmodule

`default_nettype wire

### hw/rtl/horizontal_four_tap_subpixel_filter.sv
// ----------------------------------------------------------------------------
// Horizontal four-tap subpixel filter
// A row of four cells holds the pixel window and the tap products; a final
// stage sums, rounds and clamps one output pixel per full window.
//
//   Channel  Direction  Payload
//   req      in         pixel, row_start
//   rsp      out        out_pixel
//   csr      in         index, data (four signed taps)
//
// One request is taken every cycle unless the stages hold; a result passes
// the cell shift, the product registers and the summing stage in turn after
// the request that completes its window; these form the three stages.
// Reset restores the default taps and empties the window.
// All stages hold while a result waits on rsp_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module horizontal_four_tap_subpixel_filter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [hftsf_pkg::PixelWidth-1:0]     req_pixel,
   input  wire logic                                 req_row_start,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [hftsf_pkg::PixelWidth-1:0]          rsp_out_pixel,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [hftsf_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [hftsf_pkg::TapWidth-1:0]       csr_data
);
   import hftsf_pkg::*;

   logic [TapWidth-1:0]          tap_ff [NumTaps];
   logic [FillWidth-1:0]         fill_ff;
   logic [FillWidth-1:0]         fill_in;
   logic [FillWidth-1:0]         fill_cur;
   logic                         win_vld_ff;
   logic                         win_vld_in;
   logic                         prod_vld_ff;
   logic                         rsp_valid_ff;
   logic [PixelWidth-1:0]        out_ff;
   logic [PixelWidth-1:0]        out_in;
   logic                         enable;
   logic                         accept;
   logic signed [SumWidth-1:0]   sum;
   cell_ctrl_type                ctrl;
   logic [PixelWidth-1:0]        pix_chain [NumTaps+1];
   logic signed [ProdWidth-1:0]  prod [NumTaps];

   assign enable    = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable;
   assign accept    = req_valid && enable;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff[0] <= TapLeftReset;
         tap_ff[1] <= TapCenterReset;
         tap_ff[2] <= TapRightReset;
         tap_ff[3] <= TapFarRightReset;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TAP_LEFT: begin
               tap_ff[0] <= csr_data;
            end
            CSR_TAP_CENTER: begin
               tap_ff[1] <= csr_data;
            end
            CSR_TAP_RIGHT: begin
               tap_ff[2] <= csr_data;
            end
            CSR_TAP_FAR_RIGHT: begin
               tap_ff[3] <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      fill_cur   = req_row_start ? '0 : fill_ff;
      win_vld_in = accept && (fill_cur == FillFull);
      fill_in    = fill_ff;
      if (accept) begin
         fill_in = (fill_cur == FillFull) ? FillFull : fill_cur + 1'b1;
      end
      ctrl.shift   = accept;
      ctrl.advance = enable;
   end

   assign pix_chain[NumTaps] = req_pixel;

   for (genvar i = 0; i < NumTaps; i++) begin : g_cell
      hftsf_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .pix_in   (pix_chain[i+1]),
         .tap      (tap_ff[i]),
         .pix_out  (pix_chain[i]),
         .prod_out (prod[i])
      );
   end

   always_comb begin
      sum = SumWidth'(prod[0]) + SumWidth'(prod[1]) + SumWidth'(prod[2])
          + SumWidth'(prod[3]) + SumWidth'(RoundBias);
      if (sum < 0) begin
         out_in = '0;
      end else if (sum >= SatLimit) begin
         out_in = '1;
      end else begin
         out_in = sum[RoundShift +: PixelWidth];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         win_vld_ff   <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (enable) begin
            win_vld_ff   <= win_vld_in;
            prod_vld_ff  <= win_vld_ff;
            rsp_valid_ff <= prod_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = out_ff;

   a_row_start_no_window: assert property (@(posedge clock) disable iff (reset)
      accept && req_row_start |=> !win_vld_ff)
      else $error("row start produced a full window");

   a_window_needs_fill: assert property (@(posedge clock) disable iff (reset)
      win_vld_ff |-> fill_ff == FillFull)
      else $error("window marked valid without a full fill count");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !enable |=> prod_vld_ff == $past(prod_vld_ff) && win_vld_ff == $past(win_vld_ff))
      else $error("pipeline moved during a stall");

   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      !enable |=> fill_ff == $past(fill_ff))
      else $error("fill count changed during a stall");

endmodule

`default_nettype wire

### test/horizontal_four_tap_subpixel_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horizontal four-tap subpixel filter checker
// Watches the request, result and register channels of the filter. It keeps
// its own copy of the taps and of the pixel window, computes the expected
// output pixel for every request that completes a window, and compares each
// result with the oldest expected pixel. It hands the number of results
// still owed and the number of mismatches to the test bench.
// ----------------------------------------------------------------------------

module horizontal_four_tap_subpixel_filter_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [hftsf_pkg::PixelWidth-1:0]  req_pixel,
   input  wire logic                              req_row_start,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [hftsf_pkg::PixelWidth-1:0]  rsp_out_pixel,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic [hftsf_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [hftsf_pkg::TapWidth-1:0]    csr_data,
   input  wire logic                              final_check,
   output int                                     pending_results,
   output int                                     mismatch_count
);

   import hftsf_pkg::*;

   localparam int SumMax      = (1 << (TapWidth - 1)) - 1;
   localparam int SumMin      = -(1 << (TapWidth - 1));
   localparam int PixelMax    = (1 << PixelWidth) - 1;

   logic signed [TapWidth-1:0] tap_weight [NumTaps];
   logic [PixelWidth-1:0]      row_window [NumTaps-1];
   logic [FillWidth-1:0]       window_fill;
   logic [PixelWidth-1:0]      expected_pixels [$];
   int                         results_seen;
   logic                       leftover_checked = 1'b0;

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // The span holds the four window pixels with the oldest in the top byte.
   function automatic logic [PixelWidth-1:0] filtered_pixel(
      input logic [NumTaps*PixelWidth-1:0] span
   );
      int acc;
      int weight;
      int sample;
      acc = 0;
      for (int k = 0; k < NumTaps; k++) begin
         weight = int'(tap_weight[k]);
         sample = int'(span[(NumTaps - 1 - k) * PixelWidth +: PixelWidth]);
         acc += sample * (weight >>> 1);
      end
      if (acc > SumMax) acc = SumMax;
      if (acc < SumMin) acc = SumMin;
      acc += RoundBias;
      if (acc > SumMax) acc = SumMax;
      if (acc < 0) return '0;
      acc = acc >>> RoundShift;
      if (acc > PixelMax) acc = PixelMax;
      return acc[PixelWidth-1:0];
   endfunction

   always @(posedge clock) begin : monitor
      logic [PixelWidth-1:0] expected_pixel;
      int pushed;
      int popped;
      pushed = 0;
      popped = 0;
      if (reset) begin
         tap_weight[0] = TapLeftReset;
         tap_weight[1] = TapCenterReset;
         tap_weight[2] = TapRightReset;
         tap_weight[3] = TapFarRightReset;
         for (int k = 0; k < NumTaps - 1; k++) begin
            row_window[k] = '0;
         end
         window_fill = '0;
         expected_pixels.delete();
         results_seen = 0;
         pending_results <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TAP_LEFT: tap_weight[0] = csr_data;
               CSR_TAP_CENTER: tap_weight[1] = csr_data;
               CSR_TAP_RIGHT: tap_weight[2] = csr_data;
               CSR_TAP_FAR_RIGHT: tap_weight[3] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_row_start) window_fill = '0;
            if (window_fill == FillFull) begin
               expected_pixels.push_back(filtered_pixel(
                  {row_window[0], row_window[1], row_window[2], req_pixel}));
               pushed = 1;
            end
            row_window[0] = row_window[1];
            row_window[1] = row_window[2];
            row_window[2] = req_pixel;
            if (window_fill != FillFull) window_fill++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("out_pixel %0d arrived with no request owed",
                                         rsp_out_pixel));
            end else begin
               expected_pixel = expected_pixels.pop_front();
               popped = 1;
               if (rsp_out_pixel !== expected_pixel) begin
                  report_mismatch($sformatf("result %0d: out_pixel %0d, expected %0d",
                                            results_seen, rsp_out_pixel, expected_pixel));
               end
            end
            results_seen++;
         end
         pending_results <= pending_results + pushed - popped;
      end
      if (final_check && !leftover_checked) begin
         leftover_checked = 1'b1;
         if (expected_pixels.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_pixels.size()));
         end
      end
   end

endmodule

### test/horizontal_four_tap_subpixel_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horizontal four-tap subpixel filter test bench
// Drives rows of pixels into the filter under a series of kernels, from the
// default pass-through kernel to the saturating extremes and random ones,
// while the sender and the receiver idle at random in most phases. A checker
// beside the filter predicts and compares every output pixel; this module
// makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module horizontal_four_tap_subpixel_filter_test;

   import hftsf_pkg::*;

   localparam int ResetCycles    = 12;
   localparam int DrainCycles    = 8;
   localparam int LongStall      = 300;
   localparam int NumPhases      = 10;
   localparam int ItemsPerPhase  = 170;
   localparam int StallPhase     = 7;
   localparam int PixelMax       = (1 << PixelWidth) - 1;
   localparam logic [TapWidth-1:0] TapMax      = 16'h7fff;
   localparam logic [TapWidth-1:0] TapMin      = 16'h8000;
   localparam logic [TapWidth-1:0] TapMinusOne = 16'hffff;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic [PixelWidth-1:0]  req_pixel     = '0;
   logic                   req_row_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic [PixelWidth-1:0]  rsp_out_pixel;
   logic                   csr_valid     = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index     = '0;
   logic [TapWidth-1:0]    csr_data      = '0;
   logic                   final_check   = 1'b0;
   int                     pending_results;
   int                     mismatch_count;
   int                     send_idle_pct    = 33;
   int                     recv_idle_pct    = 71;
   int                     stalls_requested = 0;

   always #2 clock = ~clock;

   horizontal_four_tap_subpixel_filter u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .req_row_start (req_row_start),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_pixel (rsp_out_pixel),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   horizontal_four_tap_subpixel_filter_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_row_start   (req_row_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_pixel   (rsp_out_pixel),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .final_check     (final_check),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   task automatic send_pixel(input logic [PixelWidth-1:0] pixel, input logic row_start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pixel;
      req_row_start <= row_start;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_register(input logic [CsrIdxWidth-1:0] index,
                                 input logic [TapWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin : receiver
      int served;
      served = 0;
      forever begin
         @(posedge clock);
         if (stalls_requested > served) begin
            served++;
            rsp_ready <= 1'b0;
            repeat (LongStall) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin : stimulus
      logic [TapWidth-1:0]   taps [NumTaps];
      logic [PixelWidth-1:0] pixel;
      logic                  row_start;
      int                    sent;
      int                    row_length;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The default kernel passes the center pixel through unchanged.
      send_pixel(8'd7, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd9, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd1, 1'b1);
      send_pixel(8'd2, 1'b0);
      send_pixel(8'd3, 1'b1);
      send_pixel(8'd4, 1'b0);
      send_pixel(8'd5, 1'b0);
      send_pixel(8'd6, 1'b0);
      send_pixel(8'd200, 1'b1);
      send_pixel(8'd201, 1'b1);
      send_pixel(8'd202, 1'b1);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);

      for (int phase = 0; phase < NumPhases; phase++) begin
         wait_until_drained();
         case (phase)
            0: begin
               taps[0] = -16'sd12;
               taps[1] = 16'sd216;
               taps[2] = 16'sd48;
               taps[3] = -16'sd6;
            end
            1: for (int k = 0; k < NumTaps; k++) taps[k] = TapMax;
            2: for (int k = 0; k < NumTaps; k++) taps[k] = TapMin;
            3: for (int k = 0; k < NumTaps; k++) taps[k] = TapMinusOne;
            4: begin
               taps[0] = TapMin;
               taps[1] = TapMax;
               taps[2] = 16'sd1;
               taps[3] = '0;
            end
            default: begin
               for (int k = 0; k < NumTaps; k++) begin
                  case ($urandom_range(5))
                     0: taps[k] = TapMax;
                     1: taps[k] = TapMin;
                     2: taps[k] = TapWidth'($urandom());
                     default: taps[k] = TapWidth'($urandom_range(600) - 300);
                  endcase
               end
               if ($urandom_range(1)) taps[1] = TapWidth'($urandom_range(192, 64));
            end
         endcase
         write_register(CSR_TAP_LEFT, taps[0]);
         write_register(CSR_TAP_CENTER, taps[1]);
         write_register(CSR_TAP_RIGHT, taps[2]);
         write_register(CSR_TAP_FAR_RIGHT, taps[3]);
         if (phase == 0 || $urandom_range(1)) begin
            write_register(CsrIdxWidth'($urandom_range((1 << CsrIdxWidth) - 1, NumTaps)),
                           TapWidth'($urandom()));
         end
         csr_valid <= 1'b0;

         if (phase < 4) begin
            send_idle_pct = 33;
            recv_idle_pct = 71;
         end else if (phase < StallPhase) begin
            send_idle_pct = 71;
            recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase == StallPhase) stalls_requested = 1;

         // Mostly whole rows; some short rows, missing and stray row starts.
         sent = 0;
         while (sent < ItemsPerPhase) begin
            if ($urandom_range(9) == 0) row_length = $urandom_range(3, 1);
            else row_length = $urandom_range(24, 4);
            for (int k = 0; k < row_length; k++) begin
               if (k == 0) row_start = ($urandom_range(9) != 0);
               else row_start = ($urandom_range(29) == 0);
               case ($urandom_range(7))
                  0: pixel = '0;
                  1: pixel = PixelWidth'(PixelMax);
                  default: pixel = PixelWidth'($urandom());
               endcase
               send_pixel(pixel, row_start);
            end
            sent += row_length;
         end
      end

      wait_until_drained();
      final_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("horizontal_four_tap_subpixel_filter_test: PASS");
      end else begin
         $display("horizontal_four_tap_subpixel_filter_test: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("%0t: run did not finish in time", $time);
      $display("horizontal_four_tap_subpixel_filter_test: FAIL");
      $finish;
   end

endmodule
